>>> design/alt_pkg.sv
// Shared types and constants for the assembly line tokenizer.
package alt_pkg;

  localparam logic [1:0] EV_TOKEN = 2'd0;
  localparam logic [1:0] EV_ERROR = 2'd1;
  localparam logic [1:0] EV_EMPTY = 2'd2;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] token_start;
    logic [8:0] token_length;
    logic [8:0] error_column;
    logic       last_in_line;
  } res_t;

endpackage

>>> design/assembly_line_tokenizer.sv
// Top level of the assembly line tokenizer.
// Takes one transaction per cycle while in_stall_o is low: a source byte or an
// end-of-line mark. The tokenizer state updates in the cycle of acceptance and
// any result reaches the output through a registered two-entry buffer, so input
// stays open while one result waits downstream; in_stall_o rises only when both
// buffer entries hold results. Sustained rate is one item per cycle while the
// output is not stalled; each item yields zero or one result.
module assembly_line_tokenizer #(
  parameter int LINE_COLUMNS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic [7:0] token_start_o,
  output logic [8:0] token_length_o,
  output logic [8:0] error_column_o,
  output logic       last_in_line_o
);

  logic          acc;
  logic          res_valid;
  logic          full;
  alt_pkg::res_t res;
  alt_pkg::res_t out_data;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  alt_step #(
    .LINE_COLUMNS(LINE_COLUMNS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .kind_i     (kind_i),
    .ch_i       (ch_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  alt_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (acc && res_valid),
    .push_data_i(res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data),
    .out_stall_i(out_stall_i)
  );

  assign event_res_o    = out_data.event_res;
  assign token_start_o  = out_data.token_start;
  assign token_length_o = out_data.token_length;
  assign error_column_o = out_data.error_column;
  assign last_in_line_o = out_data.last_in_line;

endmodule

>>> design/alt_step.sv
// Per-byte tokenizer state and result logic.
module alt_step #(
  parameter int LINE_COLUMNS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic          kind_i,
  input  logic [7:0]    ch_i,
  output logic          res_valid_o,
  output alt_pkg::res_t res_o
);

  localparam int CW = $clog2(LINE_COLUMNS + 1);

  localparam logic [1:0] CM_OUT   = 2'd0;
  localparam logic [1:0] CM_SLASH = 2'd1;
  localparam logic [1:0] CM_IN    = 2'd2;
  localparam logic [1:0] CM_STAR  = 2'd3;

  localparam logic [1:0] WC_NONE = 2'd0;
  localparam logic [1:0] WC_ONE  = 2'd1;
  localparam logic [1:0] WC_DONE = 2'd2;

  localparam logic [CW-1:0] COL_MAX = CW'(LINE_COLUMNS);

  logic [1:0]    comment_q, comment_d;
  logic [1:0]    words_q, words_d;
  logic [CW-1:0] tok_begin_q, tok_begin_d;
  logic [CW-1:0] col_q, col_d;
  logic          stopped_q, stopped_d;

  logic [CW:0]   col_inc;
  logic [CW:0]   diff;
  logic [CW:0]   diff_inc;
  logic [7:0]    c;
  logic          blank;
  logic          err;
  logic [8:0]    err_col;

  assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
  assign diff     = {1'b0, col_q} - {1'b0, tok_begin_q};
  assign diff_inc = diff + (CW+1)'(1);

  always_comb begin
    comment_d   = comment_q;
    words_d     = words_q;
    tok_begin_d = tok_begin_q;
    col_d       = col_q;
    stopped_d   = stopped_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    c           = ch_i;
    blank       = 1'b0;
    err         = 1'b0;
    err_col     = 9'(col_inc);

    if (kind_i) begin
      res_valid_o        = 1'b1;
      res_o.last_in_line = 1'b1;
      if (col_q > tok_begin_q) begin
        res_o.event_res    = alt_pkg::EV_TOKEN;
        res_o.token_start  = 8'(tok_begin_q);
        res_o.token_length = 9'(diff);
      end else begin
        res_o.event_res = alt_pkg::EV_EMPTY;
      end
      words_d     = WC_NONE;
      tok_begin_d = '0;
      col_d       = '0;
      stopped_d   = 1'b0;
    end else if (!stopped_q) begin
      if (col_q == COL_MAX) begin
        err     = 1'b1;
        err_col = 9'(LINE_COLUMNS);
      end else begin
        case (comment_q)
          CM_OUT: begin
            if (ch_i == alt_pkg::CH_SLASH) begin
              comment_d = CM_SLASH;
              c         = alt_pkg::CH_SPACE;
            end
          end
          CM_SLASH: begin
            if (ch_i != alt_pkg::CH_STAR) err = 1'b1;
            comment_d = CM_IN;
            c         = alt_pkg::CH_SPACE;
          end
          CM_IN: begin
            if (ch_i == alt_pkg::CH_STAR) comment_d = CM_STAR;
            c = alt_pkg::CH_SPACE;
          end
          default: begin
            comment_d = (ch_i == alt_pkg::CH_SLASH) ? CM_OUT : CM_IN;
            c         = alt_pkg::CH_SPACE;
          end
        endcase

        blank = (c <= alt_pkg::CH_SPACE) || c[7];

        if (!err) begin
          if (c == alt_pkg::CH_SEMI) begin
            stopped_d = 1'b1;
          end else if (blank) begin
            if (tok_begin_q != col_q) begin
              res_valid_o        = 1'b1;
              res_o.event_res    = alt_pkg::EV_TOKEN;
              res_o.token_start  = 8'(tok_begin_q);
              res_o.token_length = 9'(diff);
              if (words_q == WC_NONE) words_d = WC_ONE;
              else if (words_q == WC_ONE) words_d = WC_DONE;
            end
            tok_begin_d = CW'(col_inc);
            col_d       = CW'(col_inc);
          end else if (words_q == WC_DONE) begin
            err = 1'b1;
          end else if (c == alt_pkg::CH_COLON) begin
            res_valid_o        = 1'b1;
            res_o.event_res    = alt_pkg::EV_TOKEN;
            res_o.token_start  = 8'(tok_begin_q);
            res_o.token_length = 9'(diff_inc);
            words_d            = WC_DONE;
            tok_begin_d        = CW'(col_inc);
            col_d              = CW'(col_inc);
          end else if (c == alt_pkg::CH_COMMA) begin
            if (words_q == WC_NONE) begin
              err = 1'b1;
            end else begin
              res_valid_o        = 1'b1;
              res_o.event_res    = alt_pkg::EV_TOKEN;
              res_o.token_start  = 8'(tok_begin_q);
              res_o.token_length = 9'(diff);
              tok_begin_d        = CW'(col_inc);
              col_d              = CW'(col_inc);
            end
          end else begin
            col_d = CW'(col_inc);
          end
        end
      end

      if (err) begin
        comment_d          = CM_OUT;
        words_d            = words_q;
        tok_begin_d        = col_q;
        col_d              = col_q;
        stopped_d          = 1'b1;
        res_valid_o        = 1'b1;
        res_o              = '0;
        res_o.event_res    = alt_pkg::EV_ERROR;
        res_o.error_column = err_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q   <= CM_OUT;
      words_q     <= WC_NONE;
      tok_begin_q <= '0;
      col_q       <= '0;
      stopped_q   <= 1'b0;
    end else if (acc_i) begin
      comment_q   <= comment_d;
      words_q     <= words_d;
      tok_begin_q <= tok_begin_d;
      col_q       <= col_d;
      stopped_q   <= stopped_d;
    end
  end

endmodule

>>> design/alt_obuf.sv
// Two-entry result buffer: output register plus skid register.
module alt_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  alt_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  output alt_pkg::res_t out_data_o,
  input  logic          out_stall_i
);

  logic          out_valid_q;
  logic          skid_valid_q;
  alt_pkg::res_t out_q;
  alt_pkg::res_t skid_q;
  logic          slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (push_i) out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

>>> test/alt_checker.sv
// Checker for the assembly line tokenizer: predicts each result and compares it.
module alt_checker #(
  parameter int LINE_COLUMNS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] event_res_i,
  input  logic [7:0] token_start_i,
  input  logic [8:0] token_length_i,
  input  logic [8:0] error_column_i,
  input  logic       last_in_line_i,
  output int         n_fail_o,
  output int         n_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {CM_OUT, CM_OPEN, CM_IN, CM_CLOSE} cmt_e;
  typedef enum logic [1:0] {WC_NONE, WC_ONE, WC_DONE} words_e;

  cmt_e          cmt;
  words_e        words;
  logic [8:0]    tok_begin;
  logic [8:0]    col;
  logic          stopped;
  alt_pkg::res_t expected_q[$];

  function automatic alt_pkg::res_t flag_error(input logic [8:0] at);
    alt_pkg::res_t r;
    r = '0;
    r.event_res = alt_pkg::EV_ERROR;
    r.error_column = at;
    cmt = CM_OUT;
    tok_begin = col;
    stopped = 1'b1;
    return r;
  endfunction

  function automatic bit tokenize(input logic k, input logic [7:0] c_in,
                                  output alt_pkg::res_t r);
    logic [7:0] c;
    logic       blank;
    bit         has;
    c = c_in;
    r = '0;
    has = 1'b0;
    if (k) begin
      r.last_in_line = 1'b1;
      if (col > tok_begin) begin
        r.event_res = alt_pkg::EV_TOKEN;
        r.token_start = tok_begin[7:0];
        r.token_length = col - tok_begin;
      end else begin
        r.event_res = alt_pkg::EV_EMPTY;
      end
      words = WC_NONE;
      tok_begin = '0;
      col = '0;
      stopped = 1'b0;
      return 1'b1;
    end
    if (stopped) return 1'b0;
    if (col >= LINE_COLUMNS) begin
      r = flag_error(9'(LINE_COLUMNS));
      return 1'b1;
    end
    case (cmt)
      CM_OUT: begin
        if (c == alt_pkg::CH_SLASH) begin
          cmt = CM_OPEN;
          c = alt_pkg::CH_SPACE;
        end
      end
      CM_OPEN: begin
        if (c != alt_pkg::CH_STAR) begin
          r = flag_error(col + 9'd1);
          return 1'b1;
        end
        cmt = CM_IN;
        c = alt_pkg::CH_SPACE;
      end
      CM_IN: begin
        if (c == alt_pkg::CH_STAR) cmt = CM_CLOSE;
        c = alt_pkg::CH_SPACE;
      end
      default: begin
        cmt = (c == alt_pkg::CH_SLASH) ? CM_OUT : CM_IN;
        c = alt_pkg::CH_SPACE;
      end
    endcase
    if (c == alt_pkg::CH_SEMI) begin
      stopped = 1'b1;
      return 1'b0;
    end
    blank = (c <= 8'd32) || (c >= 8'd128);
    if (blank) begin
      if (tok_begin != col) begin
        r.event_res = alt_pkg::EV_TOKEN;
        r.token_start = tok_begin[7:0];
        r.token_length = col - tok_begin;
        has = 1'b1;
        if (words == WC_NONE) words = WC_ONE;
        else if (words == WC_ONE) words = WC_DONE;
      end
      tok_begin = col + 9'd1;
    end else begin
      if (words == WC_DONE) begin
        r = flag_error(col + 9'd1);
        return 1'b1;
      end
      if (c == alt_pkg::CH_COLON) begin
        r.event_res = alt_pkg::EV_TOKEN;
        r.token_start = tok_begin[7:0];
        r.token_length = col - tok_begin + 9'd1;
        has = 1'b1;
        words = WC_DONE;
        tok_begin = col + 9'd1;
      end else if (c == alt_pkg::CH_COMMA) begin
        if (words == WC_NONE) begin
          r = flag_error(col + 9'd1);
          return 1'b1;
        end
        r.event_res = alt_pkg::EV_TOKEN;
        r.token_start = tok_begin[7:0];
        r.token_length = col - tok_begin;
        has = 1'b1;
        tok_begin = col + 9'd1;
      end
    end
    col = col + 9'd1;
    return has;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_fail_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alt_pkg::res_t want;
    alt_pkg::res_t r;
    if (!rst_ni) begin
      cmt = CM_OUT;
      words = WC_NONE;
      tok_begin = '0;
      col = '0;
      stopped = 1'b0;
      expected_q.delete();
      n_fail_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: event_res %0d, token_start %0d, error_column %0d",
                 event_res_i, token_start_i, error_column_i);
          n_fail_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("event_res", want.event_res, event_res_i);
          check_field("token_start", want.token_start, token_start_i);
          check_field("token_length", want.token_length, token_length_i);
          check_field("error_column", want.error_column, error_column_i);
          check_field("last_in_line", want.last_in_line, last_in_line_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (tokenize(kind_i, ch_i, r)) expected_q.insert(expected_q.size(), r);
      end
    end
    n_pending_o = expected_q.size();
  end

endmodule

>>> test/assembly_line_tokenizer_tb.sv
// Testbench top for the assembly line tokenizer: stimulus, back-pressure and verdict.
module assembly_line_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_COLS = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       kind = 1'b0;
  logic [7:0] ch = 8'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] event_res;
  logic [7:0] token_start;
  logic [8:0] token_length;
  logic [8:0] error_column;
  logic       last_in_line;
  int         n_fail;
  int         n_pending;

  int         sent = 0;
  bit         send_idle = 1'b1;
  bit         recv_idle = 1'b1;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  bit         cmt_open = 1'b0;
  bit         long_done = 1'b0;
  logic [7:0] line_q[$];

  assembly_line_tokenizer #(.LINE_COLUMNS(LINE_COLS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .kind_i(kind), .ch_i(ch),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .event_res_o(event_res), .token_start_o(token_start), .token_length_o(token_length),
    .error_column_o(error_column), .last_in_line_o(last_in_line)
  );

  alt_checker #(.LINE_COLUMNS(LINE_COLS)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .kind_i(kind), .ch_i(ch),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .event_res_i(event_res), .token_start_i(token_start), .token_length_i(token_length),
    .error_column_i(error_column), .last_in_line_i(last_in_line),
    .n_fail_o(n_fail), .n_pending_o(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic offer_item(input logic k, input logic [7:0] c);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    ch <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic end_line();
    offer_item(1'b1, 8'($urandom));
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) offer_item(1'b0, s[i]);
  endtask

  task automatic send_line();
    foreach (line_q[i]) offer_item(1'b0, line_q[i]);
    end_line();
  endtask

  function automatic void add_char(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 127));
    while (c == alt_pkg::CH_SLASH || c == alt_pkg::CH_SEMI ||
           c == alt_pkg::CH_COLON || c == alt_pkg::CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return alt_pkg::CH_SPACE;
      1: return alt_pkg::CH_TAB;
      2: return 8'($urandom_range(0, 32));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic void add_word(input int n);
    repeat (n) add_char(word_char());
  endfunction

  function automatic void add_comment(input bit close);
    add_char(alt_pkg::CH_SLASH);
    add_char(alt_pkg::CH_STAR);
    repeat ($urandom_range(0, 6)) add_char(8'($urandom));
    if (close) begin
      add_char(alt_pkg::CH_STAR);
      add_char(alt_pkg::CH_SLASH);
    end
  endfunction

  function automatic void build_asm_line();
    line_q.delete();
    if (cmt_open || $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 4)) add_char(8'($urandom));
      add_char(alt_pkg::CH_STAR);
      add_char(alt_pkg::CH_SLASH);
      cmt_open = 1'b0;
    end
    repeat ($urandom_range(0, 2)) add_char(blank_char());
    if ($urandom_range(0, 3) == 0) begin
      add_word($urandom_range(1, 8));
      add_char(alt_pkg::CH_COLON);
    end else begin
      add_word($urandom_range(1, 6));
      if ($urandom_range(0, 3) != 0) begin
        add_char(blank_char());
        if ($urandom_range(0, 5) == 0) add_comment(1'b1);
        add_word($urandom_range(1, 5));
        repeat ($urandom_range(0, 3)) begin
          add_char(alt_pkg::CH_COMMA);
          if ($urandom_range(0, 3) == 0) add_char(blank_char());
          add_word($urandom_range(0, 4));
        end
      end
    end
    repeat ($urandom_range(0, 2)) add_char(blank_char());
    case ($urandom_range(0, 4))
      0: begin
        add_char(alt_pkg::CH_SEMI);
        repeat ($urandom_range(0, 8)) add_char(8'($urandom));
      end
      1: add_comment(1'b1);
      2: begin
        add_comment(1'b0);
        cmt_open = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void build_broken_line();
    line_q.delete();
    repeat ($urandom_range(1, 14)) begin
      case ($urandom_range(0, 9))
        0: add_char(alt_pkg::CH_COMMA);
        1: add_char(alt_pkg::CH_COLON);
        2: add_char(alt_pkg::CH_SEMI);
        3: add_char(alt_pkg::CH_SLASH);
        4: add_char(alt_pkg::CH_STAR);
        5: add_char(blank_char());
        9: add_char(8'($urandom));
        default: add_char(word_char());
      endcase
    end
  endfunction

  function automatic void build_noise_line();
    line_q.delete();
    repeat ($urandom_range(0, 20)) add_char(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_long_line();
    line_q.delete();
    if ($urandom_range(0, 1) == 0) begin
      add_word($urandom_range(248, 256));
      repeat ($urandom_range(0, 6)) add_char(blank_char());
    end else begin
      repeat ($urandom_range(248, 262)) add_char(blank_char());
      add_word($urandom_range(0, 6));
    end
  endfunction

  // receiver: random stalls, plus one long hold-off so the block fills and stalls its input
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        gap = recv_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int phase;
    int pick;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text(",x");
    end_line();
    send_text("l:x");
    end_line();
    send_text("/x");
    end_line();
    send_text("/*");
    end_line();
    send_text("*/a b");
    offer_item(1'b0, alt_pkg::CH_TAB);
    offer_item(1'b0, 8'h00);
    offer_item(1'b0, 8'hff);
    send_text("c");
    end_line();
    send_text("o,;z");
    end_line();

    while (sent < ITEM_TARGET) begin
      phase = (sent / 150) % 4;
      send_idle = (phase == 0 || phase == 2);
      recv_idle = (phase == 0 || phase == 3);
      if (sent >= 600) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (!long_done && sent >= 300) begin
        build_long_line();
        long_done = 1'b1;
      end else if (cmt_open || pick < 55) begin
        build_asm_line();
      end else if (pick < 75) begin
        build_broken_line();
      end else if (pick < 99) begin
        build_noise_line();
      end else begin
        build_long_line();
      end
      send_line();
    end
    in_valid <= 1'b0;

    wait (n_pending == 0);
    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/alt_pkg.sv
design/alt_step.sv
design/alt_obuf.sv
design/assembly_line_tokenizer.sv
test/alt_checker.sv
test/assembly_line_tokenizer_tb.sv
